>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define WGM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define WGM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/wgm_pkg.sv
// shared constants and types of the wildcard glob matcher
package wgm_pkg;

    // pattern storage size and derived widths
    localparam int PAT_MAX    = 32;
    localparam int VEC_W      = PAT_MAX + 1;
    localparam int LEN_W      = $clog2(PAT_MAX + 1);
    localparam int CLOSE_LVLS = $clog2(VEC_W);
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int WORD_BYTES = CFG_DATA_W / 8;

    // pattern byte codes
    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN    = 3'd0,
        CFG_WORD_A = 3'd1,
        CFG_WORD_B = 3'd2,
        CFG_WORD_C = 3'd3,
        CFG_WORD_D = 3'd4
    } t_cfg_idx;

    // decoded pattern, held in registers between configuration writes
    typedef struct packed {
        logic [LEN_W-1:0]             len;
        logic [VEC_W-1:0]             le_mask;
        logic [PAT_MAX-1:0]           lt_mask;
        logic [PAT_MAX-1:0]           star;
        logic [PAT_MAX-1:0]           any;
        logic [PAT_MAX-1:0][7:0]      bytes;
    } t_pat_info;

endpackage

>>> sv/wgm_ifs.sv
// request channels of the wildcard glob matcher

// text byte requests
interface wgm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       starts_string;

    modport source (output valid, output text_byte, output starts_string, input ready);
    modport sink   (input valid, input text_byte, input starts_string, output ready);
endinterface

// match result requests
interface wgm_out_if;
    logic valid;
    logic ready;
    logic prefix_matches;
    logic still_possible;

    modport source (output valid, output prefix_matches, output still_possible, input ready);
    modport sink   (input valid, input prefix_matches, input still_possible, output ready);
endinterface

>>> sv/wgm_cfg_regs.sv
// configuration registers with pattern decode at write time
module wgm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output wgm_pkg::t_pat_info               o_pat
);

    wgm_pkg::t_pat_info r_pat;
    logic [wgm_pkg::LEN_W-1:0] n_len;

    // saturate the requested length to the pattern store size
    always_comb begin
        if (i_cfg_data[wgm_pkg::LEN_W-1:0] > wgm_pkg::LEN_W'(wgm_pkg::PAT_MAX)) begin
            n_len = wgm_pkg::LEN_W'(wgm_pkg::PAT_MAX);
        end else begin
            n_len = i_cfg_data[wgm_pkg::LEN_W-1:0];
        end
    end

    // register writes, decoding star and any flags per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat.len     <= '0;
            r_pat.le_mask <= wgm_pkg::VEC_W'(1);
            r_pat.lt_mask <= '0;
            r_pat.star    <= '0;
            r_pat.any     <= '0;
            r_pat.bytes   <= '0;
        end else if (i_cfg_we) begin
            unique case (wgm_pkg::t_cfg_idx'(i_cfg_idx))
                wgm_pkg::CFG_LEN: begin
                    r_pat.len <= n_len;
                    for (int i = 0; i < wgm_pkg::VEC_W; i++) begin
                        r_pat.le_mask[i] <= (wgm_pkg::LEN_W'(i) <= n_len);
                    end
                    for (int i = 0; i < wgm_pkg::PAT_MAX; i++) begin
                        r_pat.lt_mask[i] <= (wgm_pkg::LEN_W'(i) < n_len);
                    end
                end
                wgm_pkg::CFG_WORD_A, wgm_pkg::CFG_WORD_B,
                wgm_pkg::CFG_WORD_C, wgm_pkg::CFG_WORD_D: begin
                    for (int j = 0; j < wgm_pkg::WORD_BYTES; j++) begin
                        r_pat.bytes[{i_cfg_idx[1:0] - 2'd1, 3'(j)}] <= i_cfg_data[8*j +: 8];
                        r_pat.star[{i_cfg_idx[1:0] - 2'd1, 3'(j)}]  <=
                            (i_cfg_data[8*j +: 8] == wgm_pkg::CH_STAR);
                        r_pat.any[{i_cfg_idx[1:0] - 2'd1, 3'(j)}]   <=
                            (i_cfg_data[8*j +: 8] == wgm_pkg::CH_ANY);
                    end
                end
                default: begin
                    // indexes past the register list are ignored
                end
            endcase
        end
    end

    assign o_pat = r_pat;

endmodule

>>> sv/wgm_star_close.sv
// closure of a position vector over star bytes, as a parallel prefix
module wgm_star_close (
    input  logic [wgm_pkg::VEC_W-1:0]   i_vec,
    input  logic [wgm_pkg::PAT_MAX-1:0] i_star,
    input  logic [wgm_pkg::VEC_W-1:0]   i_le_mask,
    output logic [wgm_pkg::VEC_W-1:0]   o_vec
);

    // g: reachable positions, p: position q is reachable from q-1 through a star
    logic [wgm_pkg::VEC_W-1:0] g [0:wgm_pkg::CLOSE_LVLS];
    logic [wgm_pkg::VEC_W-1:0] p [0:wgm_pkg::CLOSE_LVLS-1];

    assign g[0] = i_vec & i_le_mask;
    assign p[0] = {i_star, 1'b0};

    // doubling span per level
    for (genvar l = 0; l < wgm_pkg::CLOSE_LVLS; l++) begin : g_lvl
        for (genvar q = 0; q < wgm_pkg::VEC_W; q++) begin : g_bit
            if (q >= (1 << l)) begin : g_join
                assign g[l+1][q] = g[l][q] | (p[l][q] & g[l][q - (1 << l)]);
                if (l < wgm_pkg::CLOSE_LVLS - 1) begin : g_prop
                    assign p[l+1][q] = p[l][q] & p[l][q - (1 << l)];
                end
            end else begin : g_pass
                assign g[l+1][q] = g[l][q];
                if (l < wgm_pkg::CLOSE_LVLS - 1) begin : g_prop
                    assign p[l+1][q] = p[l][q];
                end
            end
        end
    end

    // drop positions that spread past the pattern end
    assign o_vec = g[wgm_pkg::CLOSE_LVLS] & i_le_mask;

endmodule

>>> sv/wgm_step.sv
// one text byte step of the position vector
module wgm_step (
    input  wgm_pkg::t_pat_info            i_pat,
    input  logic [wgm_pkg::VEC_W-1:0]     i_state,
    input  logic [7:0]                    i_byte,
    input  logic                          i_start,
    output logic [wgm_pkg::VEC_W-1:0]     o_state,
    output logic                          o_prefix,
    output logic                          o_possible
);

    logic [wgm_pkg::VEC_W-1:0]   cur_raw;
    logic [wgm_pkg::VEC_W-1:0]   cur;
    logic [wgm_pkg::VEC_W-1:0]   adv;
    logic [wgm_pkg::VEC_W-1:0]   nxt;
    logic [wgm_pkg::PAT_MAX-1:0] hit;
    logic [wgm_pkg::PAT_MAX-1:0] live;

    // a new string restarts from position zero
    assign cur_raw = i_start ? wgm_pkg::VEC_W'(1) : i_state;

    wgm_star_close u_close_cur (
        .i_vec     (cur_raw),
        .i_star    (i_pat.star),
        .i_le_mask (i_pat.le_mask),
        .o_vec     (cur)
    );

    // per-position byte match
    always_comb begin
        for (int i = 0; i < wgm_pkg::PAT_MAX; i++) begin
            hit[i] = i_pat.any[i] | (i_pat.bytes[i] == i_byte);
        end
    end

    // stars hold their position, other bytes advance on a hit
    assign live = cur[wgm_pkg::PAT_MAX-1:0] & i_pat.lt_mask;
    assign adv  = {live & ~i_pat.star & hit, 1'b0}
                | {1'b0, live & i_pat.star};

    wgm_star_close u_close_nxt (
        .i_vec     (adv),
        .i_star    (i_pat.star),
        .i_le_mask (i_pat.le_mask),
        .o_vec     (nxt)
    );

    assign o_state    = nxt;
    assign o_prefix   = nxt[i_pat.len];
    assign o_possible = |nxt;

endmodule

>>> sv/wildcard_glob_matcher.sv
// top level of the wildcard glob matcher
// Anchored glob match of a byte stream against a configured pattern of up to
// 32 bytes: '?' stands for any one byte and '*' for any run, empty included.
// Channels: i_in carries one text byte per request with a flag that marks the
// first byte of a new string; o_out returns one result per byte: whether the
// text so far matches the whole pattern, and whether a match is still
// reachable. The pattern is set through the write port (length at index 0,
// bytes 0..31 in four 64-bit words at indexes 1..4) while no request is open.
// Flow: the accepting edge loads the input register; the byte then moves on
// to the result register, which raises the result request, at an edge when
// the result register holds no stalled result.
// Throughput: one byte per cycle while the receiver does not stall; the
// position vector is closed over stars, advanced and closed again
// combinationally between the input register and the state register.
// Reset clears the pattern, the pipeline and the position vector to position
// zero. When the receiver stalls, the result register holds its request and
// the input register still takes one more byte before ready drops.
module wildcard_glob_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    wgm_in_if.sink                          i_in,
    wgm_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    wgm_pkg::t_pat_info            pat;
    logic                          r_s1_valid;
    logic [7:0]                    r_s1_byte;
    logic                          r_s1_start;
    logic [wgm_pkg::VEC_W-1:0]     r_state;
    logic                          r_out_valid;
    logic                          r_out_prefix;
    logic                          r_out_possible;
    logic [wgm_pkg::VEC_W-1:0]     n_state;
    logic                          n_prefix;
    logic                          n_possible;
    logic                          out_en;
    logic                          s1_fire;

    wgm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pat      (pat)
    );

    // pipeline flow control
    assign out_en     = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && out_en;
    assign i_in.ready = !r_s1_valid || out_en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte  <= i_in.text_byte;
            r_s1_start <= i_in.starts_string;
        end
    end

    wgm_step u_step (
        .i_pat      (pat),
        .i_state    (r_state),
        .i_byte     (r_s1_byte),
        .i_start    (r_s1_start),
        .o_state    (n_state),
        .o_prefix   (n_prefix),
        .o_possible (n_possible)
    );

    // position vector, updated once per byte as it moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wgm_pkg::VEC_W'(1);
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_prefix   <= n_prefix;
            r_out_possible <= n_possible;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.prefix_matches = r_out_prefix;
    assign o_out.still_possible = r_out_possible;

endmodule

>>> sv/wgm_checker.sv
// port-level checks of the wildcard glob matcher, bound to the top level
`include "assert_macros.svh"

module wgm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_prefix,
    input logic i_out_possible
);

    // a full match means a position is still live
    `WGM_ASSERT(a_prefix_live, i_clk, i_rst_n, (i_out_valid && i_out_prefix) |-> i_out_possible, "match reported with no live position")

    // a stalled result request stays up
    `WGM_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result request dropped while stalled")

    // a byte taken moves on to the result register when the result register is not stalled
    `WGM_ASSERT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 (i_out_ready || !i_out_valid) |=> i_out_valid, "result missing two cycles after request")

    // reset empties the result register
    `WGM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result request shown after reset")

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_prefix   (o_out.prefix_matches),
    .i_out_possible (o_out.still_possible)
);
